/* src/free_span_from_exclusions_top_defines.svh */
// Assertion macros shared by the span logic.
// Included by fse_ctrl, the module that carries concurrent checks; no other dependencies.
`ifndef FREE_SPAN_FROM_EXCLUSIONS_TOP_DEFINES_SVH
`define FREE_SPAN_FROM_EXCLUSIONS_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FSE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define FSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* src/fse_pkg.sv */
// Shared types, codes and sizes for the free span block.
// No dependencies; used by every module of the block.
package fse_pkg;

	localparam int MaxRegions = 16;
	localparam int CoordBits  = 24;
	localparam int IdxW       = $clog2(MaxRegions);
	localparam int CntW       = $clog2(MaxRegions + 1);
	localparam int UBits      = CoordBits - 1;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic [1:0] STAT_SPAN = 2'd0;
	localparam logic [1:0] STAT_NONE = 2'd1;
	localparam logic [1:0] STAT_DONE = 2'd2;
	localparam logic [1:0] STAT_FULL = 2'd3;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0]                  command;
		logic signed [CoordBits-1:0] rect_left;
		logic signed [CoordBits-1:0] rect_top;
		logic signed [CoordBits-1:0] rect_wide;
		logic signed [CoordBits-1:0] rect_tall;
		logic signed [CoordBits-1:0] band_top;
	} item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [UBits-1:0] span_start;
		logic [UBits-1:0] span_width;
		logic             last;
	} result_t;

	// Clipped span of one stored region against the current band.
	typedef struct packed {
		logic             hit;
		logic [UBits-1:0] lo;
		logic [UBits-1:0] hi;
	} span_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILT,
		ST_SCAN,
		ST_FIN
	} state_t;

endpackage

/* src/free_span_from_exclusions_top.sv */
// Top level: configuration registers, region store and query sequencer; uses fse_pkg,
// fse_regions and fse_ctrl. Clear, add and unused commands: one word the cycle after start.
// Query: a filter step per stored region, then repeated passes over the n clipped spans and
// a closing state; a query with a zero register gives one none word like the commands above.
// Words come at most one per pass and cannot be stalled; the last word comes in the first cycle busy is low.
// arst_n empties the store and zeroes both registers; no clearing pass is needed.
module free_span_from_exclusions_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  fse_pkg::item_t            item,
	output logic                      busy,
	output fse_pkg::result_t          result,
	output logic                      result_strobe,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [fse_pkg::UBits-1:0] cfg_data
);
	logic [fse_pkg::UBits-1:0]            width_q, height_q;
	logic                                 accept, full;
	logic [fse_pkg::CntW-1:0]             count;
	logic [fse_pkg::IdxW-1:0]             rd_idx;
	logic signed [fse_pkg::CoordBits-1:0] band_y;
	fse_pkg::span_t                       span;

	assign accept = start && !busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == fse_pkg::CFG_WIDTH) begin
				width_q <= cfg_data;
			end else begin
				height_q <= cfg_data;
			end
		end
	end

	fse_regions u_regions (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (accept && item.command == fse_pkg::CMD_CLEAR),
		.add          (accept && item.command == fse_pkg::CMD_ADD),
		.item         (item),
		.rd_idx       (rd_idx),
		.band_y       (band_y),
		.band_height  (height_q),
		.layout_width (width_q),
		.count        (count),
		.full         (full),
		.span         (span)
	);

	fse_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.command       (item.command),
		.band_top      (item.band_top),
		.full          (full),
		.count         (count),
		.layout_width  (width_q),
		.band_height   (height_q),
		.span          (span),
		.rd_idx        (rd_idx),
		.band_y        (band_y),
		.busy          (busy),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule

/* src/fse_regions.sv */
// Region store with fill count, and the band filter and horizontal clip.
// Depends on fse_pkg.
module fse_regions (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 clear,
	input  logic                                 add,
	input  fse_pkg::item_t                       item,
	input  logic [fse_pkg::IdxW-1:0]             rd_idx,
	input  logic signed [fse_pkg::CoordBits-1:0] band_y,
	input  logic [fse_pkg::UBits-1:0]            band_height,
	input  logic [fse_pkg::UBits-1:0]            layout_width,
	output logic [fse_pkg::CntW-1:0]             count,
	output logic                                 full,
	output fse_pkg::span_t                       span
);
	localparam int CB = fse_pkg::CoordBits;

	logic signed [CB-1:0] left_q [fse_pkg::MaxRegions];
	logic signed [CB-1:0] top_q  [fse_pkg::MaxRegions];
	logic signed [CB-1:0] wide_q [fse_pkg::MaxRegions];
	logic signed [CB-1:0] tall_q [fse_pkg::MaxRegions];
	logic [fse_pkg::CntW-1:0] count_q;

	logic signed [CB:0] bot, top_e, low_e, y_e, wid_e, sum, lo_s, hi_s;

	assign full  = (count_q == fse_pkg::CntW'(fse_pkg::MaxRegions));
	assign count = count_q;

	// Fill count; clear empties the store at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (add && !full) begin
			count_q <= count_q + 1'b1;
		end
	end

	// Region words are written at the fill position.
	always_ff @(posedge clk) begin
		if (add && !full) begin
			left_q[count_q[fse_pkg::IdxW-1:0]] <= item.rect_left;
			top_q[count_q[fse_pkg::IdxW-1:0]]  <= item.rect_top;
			wide_q[count_q[fse_pkg::IdxW-1:0]] <= item.rect_wide;
			tall_q[count_q[fse_pkg::IdxW-1:0]] <= item.rect_tall;
		end
	end

	// Vertical overlap test on raw values, then clip to [0, layout_width].
	always_comb begin
		y_e   = (CB+1)'(band_y);
		bot   = y_e + $signed({2'b00, band_height});
		top_e = (CB+1)'(top_q[rd_idx]);
		low_e = top_e + (CB+1)'(tall_q[rd_idx]);
		wid_e = $signed({2'b00, layout_width});
		sum   = (CB+1)'(left_q[rd_idx]) + (CB+1)'(wide_q[rd_idx]);
		lo_s  = left_q[rd_idx][CB-1] ? '0 : (CB+1)'(left_q[rd_idx]);
		hi_s  = (sum > wid_e) ? wid_e : sum;
		span.hit = (top_e < bot) && (low_e > y_e) && (hi_s > lo_s);
		span.lo  = lo_s[fse_pkg::UBits-1:0];
		span.hi  = hi_s[fse_pkg::UBits-1:0];
	end

endmodule

/* src/fse_ctrl.sv */
// Query sequencer: span scratch, repeated extend/min-search passes, result register.
// Depends on fse_pkg and the assertion macro header.
`include "free_span_from_exclusions_top_defines.svh"

module fse_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic [1:0]                           command,
	input  logic signed [fse_pkg::CoordBits-1:0] band_top,
	input  logic                                 full,
	input  logic [fse_pkg::CntW-1:0]             count,
	input  logic [fse_pkg::UBits-1:0]            layout_width,
	input  logic [fse_pkg::UBits-1:0]            band_height,
	input  fse_pkg::span_t                       span,
	output logic [fse_pkg::IdxW-1:0]             rd_idx,
	output logic signed [fse_pkg::CoordBits-1:0] band_y,
	output logic                                 busy,
	output fse_pkg::result_t                     result,
	output logic                                 result_strobe
);
	localparam int UB = fse_pkg::UBits;

	fse_pkg::state_t state_q, state_n;

	logic [UB-1:0] lo_q [fse_pkg::MaxRegions];
	logic [UB-1:0] hi_q [fse_pkg::MaxRegions];

	logic [fse_pkg::IdxW-1:0] idx_q, idx_n;
	logic [fse_pkg::CntW-1:0] n_q, n_n;
	logic [UB-1:0]            cur_q, cur_n, minlo_q, minlo_n;
	logic                     chg_q, chg_n, minf_q, minf_n;
	logic                     pend_q, pend_n;
	logic [UB-1:0]            pst_q, pst_n, pwd_q, pwd_n;
	logic signed [fse_pkg::CoordBits-1:0] y_q;
	fse_pkg::result_t         res_q, res_n;
	logic                     strobe_q, strobe_n;

	logic          elem, ext, cand, pass_end, filt_end, wr_en;
	logic [UB-1:0] e_lo, e_hi, ecur;
	logic [1:0]    done_stat;

	assign rd_idx        = idx_q;
	assign band_y        = y_q;
	assign busy          = (state_q != fse_pkg::ST_IDLE);
	assign result        = res_q;
	assign result_strobe = strobe_q;

	// Element compare unit shared by every pass.
	always_comb begin
		elem     = (n_q != '0);
		e_lo     = lo_q[idx_q];
		e_hi     = hi_q[idx_q];
		ext      = elem && (e_lo <= cur_q) && (e_hi > cur_q);
		ecur     = ext ? e_hi : cur_q;
		cand     = elem && (e_lo > cur_q) && (!minf_q || e_lo < minlo_q);
		pass_end = !elem || ((fse_pkg::CntW'(idx_q) + 1'b1) == n_q);
		filt_end = (count == '0) || ((fse_pkg::CntW'(idx_q) + 1'b1) == count);
		wr_en    = (state_q == fse_pkg::ST_FILT) && (count != '0) && span.hit;
		done_stat = (command == fse_pkg::CMD_ADD && full) ?
			fse_pkg::STAT_FULL : fse_pkg::STAT_DONE;
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			fse_pkg::ST_IDLE: begin
				if (accept && command == fse_pkg::CMD_QUERY &&
					layout_width != '0 && band_height != '0) begin
					state_n = fse_pkg::ST_FILT;
				end
			end
			fse_pkg::ST_FILT: begin
				if (filt_end) begin
					state_n = fse_pkg::ST_SCAN;
				end
			end
			fse_pkg::ST_SCAN: begin
				if (pass_end && !(chg_q || ext) && !(minf_q || cand)) begin
					if (cur_q < layout_width) begin
						state_n = fse_pkg::ST_FIN;
					end else begin
						state_n = fse_pkg::ST_IDLE;
					end
				end
			end
			fse_pkg::ST_FIN: begin
				state_n = fse_pkg::ST_IDLE;
			end
			default: state_n = fse_pkg::ST_IDLE;
		endcase
	end

	// Datapath updates and result words.
	always_comb begin
		idx_n    = idx_q;
		n_n      = n_q;
		cur_n    = cur_q;
		chg_n    = chg_q;
		minf_n   = minf_q;
		minlo_n  = minlo_q;
		pend_n   = pend_q;
		pst_n    = pst_q;
		pwd_n    = pwd_q;
		res_n    = res_q;
		strobe_n = 1'b0;
		unique case (state_q)
			fse_pkg::ST_IDLE: begin
				idx_n  = '0;
				n_n    = '0;
				cur_n  = '0;
				chg_n  = 1'b0;
				minf_n = 1'b0;
				pend_n = 1'b0;
				if (accept) begin
					if (command != fse_pkg::CMD_QUERY) begin
						strobe_n = 1'b1;
						res_n    = '{done_stat, '0, '0, 1'b1};
					end else if (layout_width == '0 || band_height == '0) begin
						strobe_n = 1'b1;
						res_n    = '{fse_pkg::STAT_NONE, '0, '0, 1'b1};
					end
				end
			end
			fse_pkg::ST_FILT: begin
				if (wr_en) begin
					n_n = n_q + 1'b1;
				end
				idx_n = filt_end ? '0 : idx_q + 1'b1;
			end
			fse_pkg::ST_SCAN: begin
				cur_n  = ecur;
				chg_n  = chg_q || ext;
				if (cand) begin
					minf_n  = 1'b1;
					minlo_n = e_lo;
				end
				idx_n = pass_end ? '0 : idx_q + 1'b1;
				if (pass_end) begin
					chg_n  = 1'b0;
					minf_n = 1'b0;
					if (!(chg_q || ext)) begin
						if (minf_q || cand) begin
							// Gap up to the nearest start right of the cover.
							strobe_n = pend_q;
							res_n    = '{fse_pkg::STAT_SPAN, pst_q, pwd_q, 1'b0};
							pend_n   = 1'b1;
							pst_n    = cur_q;
							pwd_n    = (cand ? e_lo : minlo_q) - cur_q;
							cur_n    = cand ? e_lo : minlo_q;
						end else if (cur_q < layout_width) begin
							strobe_n = pend_q;
							res_n    = '{fse_pkg::STAT_SPAN, pst_q, pwd_q, 1'b0};
							pend_n   = 1'b1;
							pst_n    = cur_q;
							pwd_n    = layout_width - cur_q;
						end else begin
							strobe_n = 1'b1;
							res_n    = pend_q ?
								'{fse_pkg::STAT_SPAN, pst_q, pwd_q, 1'b1} :
								'{fse_pkg::STAT_NONE, '0, '0, 1'b1};
						end
					end
				end
			end
			fse_pkg::ST_FIN: begin
				strobe_n = 1'b1;
				res_n    = '{fse_pkg::STAT_SPAN, pst_q, pwd_q, 1'b1};
				pend_n   = 1'b0;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= fse_pkg::ST_IDLE;
			strobe_q <= 1'b0;
			pend_q   <= 1'b0;
			idx_q    <= '0;
			n_q      <= '0;
			chg_q    <= 1'b0;
			minf_q   <= 1'b0;
		end else begin
			state_q  <= state_n;
			strobe_q <= strobe_n;
			pend_q   <= pend_n;
			idx_q    <= idx_n;
			n_q      <= n_n;
			chg_q    <= chg_n;
			minf_q   <= minf_n;
		end
	end

	// Payload registers and span scratch.
	always_ff @(posedge clk) begin
		cur_q   <= cur_n;
		minlo_q <= minlo_n;
		pst_q   <= pst_n;
		pwd_q   <= pwd_n;
		res_q   <= res_n;
		if (state_q == fse_pkg::ST_IDLE && accept) begin
			y_q <= band_top;
		end
		if (wr_en) begin
			lo_q[n_q[fse_pkg::IdxW-1:0]] <= span.lo;
			hi_q[n_q[fse_pkg::IdxW-1:0]] <= span.hi;
		end
	end

	`FSE_ASSERT_NEXT(a_simple_one_word, accept && !busy && command != fse_pkg::CMD_QUERY, result_strobe && result.last)
	`FSE_ASSERT_NOW(a_span_nonempty, result_strobe && result.status == fse_pkg::STAT_SPAN, result.span_width != '0)
	`FSE_ASSERT_NOW(a_fin_has_pending, state_q == fse_pkg::ST_FIN, pend_q)
	`FSE_ASSERT_NOW(a_scratch_bound, state_q == fse_pkg::ST_SCAN, n_q <= count)

endmodule

/* sim/free_span_from_exclusions_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for free_span_from_exclusions_top: region loads, clears and
// line queries against an in-bench span predictor. Depends on fse_pkg and the block.
module free_span_from_exclusions_top_tb;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	fse_pkg::item_t            item;
	logic                      busy;
	fse_pkg::result_t          result;
	logic                      result_strobe;
	logic                      cfg_we;
	logic                      cfg_index;
	logic [fse_pkg::UBits-1:0] cfg_data;

	free_span_from_exclusions_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
		.result(result), .result_strobe(result_strobe), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state: its own copy of the store and both registers.
	typedef struct {
		longint left;
		longint top;
		longint wide;
		longint tall;
	} region_rec_t;

	region_rec_t      region_copy[fse_pkg::MaxRegions];
	int               stored_regions;
	longint           line_width;
	longint           line_height;
	fse_pkg::result_t expected_words[$];
	int               mismatches;
	bit               quiet_phase;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic fse_pkg::result_t make_word(logic [1:0] st, longint s, longint w,
	                                               bit lst);
		fse_pkg::result_t r;
		r.status     = st;
		r.span_start = s[fse_pkg::UBits-1:0];
		r.span_width = w[fse_pkg::UBits-1:0];
		r.last       = lst;
		return r;
	endfunction

	// Appends one expected word at the tail of the queue.
	function automatic void queue_word(fse_pkg::result_t w);
		expected_words.insert(expected_words.size(), w);
	endfunction

	// Free gaps of one band, queued in order with the final one marked last.
	task automatic predict_free_spans(longint y);
		longint lo_q[$];
		longint hi_q[$];
		longint lo, hi, tl, th, cur, bot;
		int     n, j, m, k;
		fse_pkg::result_t outw[$];
		bot = y + line_height;
		if (line_width == 0 || line_height == 0) begin
			queue_word(make_word(fse_pkg::STAT_NONE, 0, 0, 1));
			return;
		end
		for (int i = 0; i < stored_regions; i++) begin
			if (!(region_copy[i].top < bot &&
			      region_copy[i].top + region_copy[i].tall > y)) continue;
			lo = region_copy[i].left > 0 ? region_copy[i].left : 0;
			hi = region_copy[i].left + region_copy[i].wide;
			if (hi > line_width) hi = line_width;
			if (hi > lo) begin
				lo_q.insert(lo_q.size(), lo);
				hi_q.insert(hi_q.size(), hi);
			end
		end
		n = lo_q.size();
		if (n == 0) begin
			queue_word(make_word(fse_pkg::STAT_SPAN, 0, line_width, 1));
			return;
		end
		// Insertion sort by start, then end.
		for (int i = 1; i < n; i++) begin
			tl = lo_q[i];
			th = hi_q[i];
			j = i;
			while (j > 0 && (lo_q[j-1] > tl || (lo_q[j-1] == tl && hi_q[j-1] > th))) begin
				lo_q[j] = lo_q[j-1];
				hi_q[j] = hi_q[j-1];
				j--;
			end
			lo_q[j] = tl;
			hi_q[j] = th;
		end
		// Merge spans that touch or overlap.
		m = 1;
		for (int i = 1; i < n; i++) begin
			if (lo_q[i] > hi_q[m-1]) begin
				lo_q[m] = lo_q[i];
				hi_q[m] = hi_q[i];
				m++;
			end else if (hi_q[i] > hi_q[m-1]) begin
				hi_q[m-1] = hi_q[i];
			end
		end
		cur = 0;
		for (int i = 0; i < m; i++) begin
			if (lo_q[i] > cur)
				outw.insert(outw.size(), make_word(fse_pkg::STAT_SPAN, cur, lo_q[i] - cur, 0));
			if (hi_q[i] > cur) cur = hi_q[i];
		end
		if (cur < line_width)
			outw.insert(outw.size(), make_word(fse_pkg::STAT_SPAN, cur, line_width - cur, 0));
		k = outw.size();
		if (k == 0) begin
			queue_word(make_word(fse_pkg::STAT_NONE, 0, 0, 1));
			return;
		end
		outw[k-1].last = 1'b1;
		foreach (outw[i]) queue_word(outw[i]);
	endtask

	task automatic predict_item(fse_pkg::item_t it);
		unique case (it.command)
			fse_pkg::CMD_CLEAR: begin
				stored_regions = 0;
				queue_word(make_word(fse_pkg::STAT_DONE, 0, 0, 1));
			end
			fse_pkg::CMD_ADD: begin
				if (stored_regions >= fse_pkg::MaxRegions) begin
					queue_word(make_word(fse_pkg::STAT_FULL, 0, 0, 1));
				end else begin
					region_copy[stored_regions].left = longint'(it.rect_left);
					region_copy[stored_regions].top  = longint'(it.rect_top);
					region_copy[stored_regions].wide = longint'(it.rect_wide);
					region_copy[stored_regions].tall = longint'(it.rect_tall);
					stored_regions++;
					queue_word(make_word(fse_pkg::STAT_DONE, 0, 0, 1));
				end
			end
			fse_pkg::CMD_QUERY: predict_free_spans(longint'(it.band_top));
			default: queue_word(make_word(fse_pkg::STAT_DONE, 0, 0, 1));
		endcase
	endtask

	// Result checker: every strobed word against the oldest expectation.
	always @(posedge clk) begin
		fse_pkg::result_t want;
		if (arst_n && result_strobe) begin
			if (expected_words.size() == 0) begin
				$error("unexpected result word status=%0d", result.status);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				if (result.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, result.status);
					mismatches++;
				end
				if (result.span_start !== want.span_start) begin
					$error("span_start expected %0d actual %0d",
					       want.span_start, result.span_start);
					mismatches++;
				end
				if (result.span_width !== want.span_width) begin
					$error("span_width expected %0d actual %0d",
					       want.span_width, result.span_width);
					mismatches++;
				end
				if (result.last !== want.last) begin
					$error("last expected %0d actual %0d", want.last, result.last);
					mismatches++;
				end
			end
		end
	end

	// Send one word, with an optional random gap ahead of it. start stays high after
	// the accepting edge so that a following word can go out at once; busy is sampled
	// on the falling edge, where it holds the value seen by the next rising edge.
	task automatic send_item(fse_pkg::item_t it);
		bit was_busy;
		if (!quiet_phase && $urandom_range(99) < 14) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do begin
			@(negedge clk);
			was_busy = busy;
			@(posedge clk);
		end while (was_busy);
		predict_item(it);
	endtask

	task automatic drain;
		start <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, longint val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[fse_pkg::UBits-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == fse_pkg::CFG_WIDTH) line_width = val[fse_pkg::UBits-1:0];
		else line_height = val[fse_pkg::UBits-1:0];
	endtask

	function automatic fse_pkg::item_t cmd_item(logic [1:0] c);
		fse_pkg::item_t it;
		it = '0;
		it.command = c;
		return it;
	endfunction

	function automatic fse_pkg::item_t add_item(longint l, longint t, longint w, longint h);
		fse_pkg::item_t it;
		it = cmd_item(fse_pkg::CMD_ADD);
		it.rect_left = l[fse_pkg::CoordBits-1:0];
		it.rect_top  = t[fse_pkg::CoordBits-1:0];
		it.rect_wide = w[fse_pkg::CoordBits-1:0];
		it.rect_tall = h[fse_pkg::CoordBits-1:0];
		return it;
	endfunction

	function automatic fse_pkg::item_t query_item(longint y);
		fse_pkg::item_t it;
		it = cmd_item(fse_pkg::CMD_QUERY);
		it.band_top = y[fse_pkg::CoordBits-1:0];
		return it;
	endfunction

	// Directed: zero registers, empty store, full store, extremes, unused code.
	task automatic test_directed;
		send_item(query_item(0));
		write_reg(fse_pkg::CFG_WIDTH, 1000);
		send_item(query_item(0));
		write_reg(fse_pkg::CFG_HEIGHT, 100);
		send_item(query_item(0));
		send_item(add_item(100, 0, 200, 50));
		send_item(add_item(300, 10, 100, 50));
		send_item(add_item(-50, 0, 80, 50));
		send_item(add_item(500, 0, -20, 50));
		send_item(add_item(600, 40, 100, -80));
		send_item(query_item(0));
		send_item(query_item(-8388608));
		send_item(add_item(-8388608, -8388608, 8388607, 8388607));
		send_item(query_item(8388607));
		send_item(query_item(0));
		send_item(cmd_item(2'd3));
		send_item(cmd_item(fse_pkg::CMD_CLEAR));
		for (int i = 0; i < fse_pkg::MaxRegions + 1; i++)
			send_item(add_item(i * 60, 0, 30, 10));
		send_item(query_item(5));
		write_reg(fse_pkg::CFG_WIDTH, 8388607);
		write_reg(fse_pkg::CFG_HEIGHT, 8388607);
		send_item(query_item(-8388608));
		send_item(add_item(8388607, 8388607, 8388607, -8388608));
		send_item(cmd_item(fse_pkg::CMD_CLEAR));
		send_item(query_item(8388607));
	endtask

	function automatic fse_pkg::item_t random_item(longint wmax, longint hmax);
		fse_pkg::item_t it;
		int             pick;
		logic [127:0]   raw;
		pick = $urandom_range(99);
		if (pick < 8) begin
			// Raw noise over every bit of every field.
			raw = {$urandom, $urandom, $urandom, $urandom};
			it  = fse_pkg::item_t'(raw[$bits(fse_pkg::item_t)-1:0]);
		end else if (pick < 12) begin
			it = cmd_item(fse_pkg::CMD_CLEAR);
		end else if (pick < 15) begin
			it = cmd_item(2'd3);
		end else if (pick < 62) begin
			it = add_item(longint'($urandom_range(0, wmax + 40)) - 20,
			              longint'($urandom_range(0, hmax * 4)) - hmax,
			              longint'($urandom_range(0, wmax / 2 + 10)) - 5,
			              longint'($urandom_range(0, hmax * 2)) - 4);
			it.band_top = fse_pkg::CoordBits'($urandom);
		end else begin
			it = query_item(longint'($urandom_range(0, hmax * 4)) - hmax * 2);
			it.rect_left = fse_pkg::CoordBits'($urandom);
			it.rect_top  = fse_pkg::CoordBits'($urandom);
		end
		return it;
	endfunction

	// Random phases over several register settings, extremes included.
	task automatic test_random;
		longint wset[4] = '{1, 256, 5000, 8388607};
		longint hset[4] = '{1, 64, 2000, 8388607};
		for (int p = 0; p < 8; p++) begin
			write_reg(fse_pkg::CFG_WIDTH, p < 4 ? wset[p] : $urandom_range(0, 8388607));
			write_reg(fse_pkg::CFG_HEIGHT, p < 4 ? hset[3 - p] : $urandom_range(1, 8388607));
			send_item(cmd_item(fse_pkg::CMD_CLEAR));
			quiet_phase = (p == 2);
			for (int i = 0; i < 48; i++)
				send_item(random_item(line_width > 8388000 ? 8000000 : line_width + 50,
				                      line_height > 4000 ? 4000 : line_height + 8));
			quiet_phase = 0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = fse_pkg::CFG_WIDTH;
		cfg_data = '0;
		stored_regions = 0;
		line_width = 0;
		line_height = 0;
		mismatches = 0;
		quiet_phase = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		drain();
		repeat (600) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
